>>> hdl/bba_pkg.sv
package bba_pkg;

  localparam int CFG_W = 17;
  localparam int IDX_W = 16;
  localparam int MAX_WORD_BITS = 64;
  localparam int MAX_WORD_LOG = 6;

  localparam int MAP_BLOCKS_DEF = 65536;
  localparam int MAP_WORD_BITS_DEF = 64;

  localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RESET = 17'h10000;
  localparam logic [CFG_W-1:0] RESERVED_BLOCKS_RESET = 17'h00000;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic {
    REG_TOTAL_BLOCKS    = 1'b0,
    REG_RESERVED_BLOCKS = 1'b1
  } reg_index_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] block_index;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_block;
    logic             bit_value;
    logic [CFG_W-1:0] free_blocks;
    status_t          status;
  } response_t;

  // Ones in every bit below n
  function automatic logic [MAX_WORD_BITS-1:0] low_mask(input logic [31:0] n);
    logic [MAX_WORD_BITS-1:0] m;
    if (n >= 32'(MAX_WORD_BITS)) begin
      m = '1;
    end else begin
      m = (MAX_WORD_BITS'(1) << n[MAX_WORD_LOG-1:0]) - MAX_WORD_BITS'(1);
    end
    return m;
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

  function automatic logic [MAX_WORD_LOG-1:0] lowest_set(input logic [MAX_WORD_BITS-1:0] v);
    logic [MAX_WORD_LOG-1:0] r;
    r = '0;
    for (int i = MAX_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = MAX_WORD_LOG'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/bba_stream_if.sv
interface bba_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/block_bitmap_allocator.sv
// First-fit block allocator over a usage bitmap (one bit per block, 1 = used).
// Channels: request (cmd, block_index) and response (result_block, bit_value,
// free_blocks, status), each a valid/ready stream; a transfer completes when
// valid and ready are both high. Registers total_blocks and reserved_blocks
// are written through cfg_we/cfg_index/cfg_wdata; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// One command is worked on at a time; the response register holds a result
// while the next request is taken, so a stalled receiver blocks only once a
// second result is ready to leave.
// After the request: free and in-range query go through the access state;
// an out-of-range index or an allocate on an empty count goes straight to
// done; allocate scans the summary (one summary word of MAP_WORD_BITS
// full-flags per cycle, 16 at most for the default map), then updates the
// found word; init rewrites the bitmap (one bitmap word written per cycle).
// The bitmap and the full-word summary sit in two single-port-write RAMs with
// registered reads; every allocate or free is a read, modify, write back.
// After reset a clearing pass over all NUM_WORDS words (1024 by default)
// zeroes both RAMs; request.ready stays low until it ends. The free count
// is zero after reset; before the first init only a free can raise it.
module block_bitmap_allocator #(
  parameter int MAP_BLOCKS = bba_pkg::MAP_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  bba_pkg::reg_index_t         cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_wdata,
  bba_stream_if.sink                  request,
  bba_stream_if.source                response
);

  localparam int WB = MAP_WORD_BITS;
  localparam int WLOG = $clog2(MAP_WORD_BITS);
  localparam int NUM_WORDS = (MAP_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int NUM_GROUPS = (NUM_WORDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GAW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CW = bba_pkg::CFG_W;
  localparam int IW = bba_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WORD,
    S_ACCESS,
    S_DONE
  } state_t;

  state_t                 state;
  logic [CW-1:0]          total_blocks;
  logic [CW-1:0]          reserved_blocks;
  logic [CW-1:0]          free_count;
  logic [CW-1:0]          res_q;
  logic                   init_op;
  logic [AW-1:0]          sweep;
  logic [AW-1:0]          word_q;
  logic [GAW-1:0]         grp;
  logic [WLOG-1:0]        bit_q;
  bba_pkg::cmd_t          cmd_q;
  logic [WB-1:0]          sum_hold;
  logic [IW-1:0]          pend_block;
  logic                   pend_bit;
  bba_pkg::status_t       pend_status;
  bba_pkg::response_t     rsp;
  logic                   rsp_valid;

  logic                   map_we;
  logic [AW-1:0]          map_waddr;
  logic [WB-1:0]          map_wdata;
  logic [AW-1:0]          map_raddr;
  logic [WB-1:0]          map_rdata;
  logic                   sum_we;
  logic [GAW-1:0]         sum_waddr;
  logic [WB-1:0]          sum_wdata;
  logic [GAW-1:0]         sum_raddr;
  logic [WB-1:0]          sum_rdata;

  logic [CW-1:0]          size;
  logic [CW-1:0]          res_now;
  logic [31:0]            nwords;
  logic [31:0]            req_word;
  logic [31:0]            req_group;
  logic                   in_range;
  logic [31:0]            gbase;
  logic [bba_pkg::MAX_WORD_BITS-1:0] gmask;
  logic [WB-1:0]          gfree;
  logic [bba_pkg::MAX_WORD_LOG-1:0]  gj_full;
  logic [WLOG-1:0]        gj;
  logic [31:0]            found_word;
  logic                   last_group;
  logic [31:0]            wbase;
  logic [bba_pkg::MAX_WORD_BITS-1:0] wmask;
  logic [WB-1:0]          wfree;
  logic [bba_pkg::MAX_WORD_LOG-1:0]  wp_full;
  logic [WLOG-1:0]        wp;
  logic [WB-1:0]          wset;
  logic [31:0]            word_group;
  logic [WB-1:0]          flag_bit;
  logic [WB-1:0]          idx_bit;
  logic [31:0]            sbase;
  logic [bba_pkg::MAX_WORD_BITS-1:0] sword_mask;
  logic [bba_pkg::MAX_WORD_BITS-1:0] sflag_mask;
  logic [WB-1:0]          sweep_word;
  logic [WB-1:0]          sweep_flags;
  logic [MAP_WORD_BITS-1:0] one_bit;

  assign one_bit = WB'(1);

  assign size = (32'(total_blocks) < 32'(MAP_BLOCKS)) ? total_blocks : CW'(MAP_BLOCKS);
  assign res_now = (reserved_blocks < size) ? reserved_blocks : size;
  assign nwords = (32'(size) + 32'(WB - 1)) >> WLOG;

  assign req_word = 32'(request.payload.block_index) >> WLOG;
  assign req_group = req_word >> WLOG;
  assign in_range = 32'(request.payload.block_index) < 32'(size);

  assign gbase = 32'(grp) << WLOG;
  assign gmask = bba_pkg::low_mask(bba_pkg::sat_sub(nwords, gbase));
  assign gfree = ~sum_rdata & gmask[WB-1:0];
  assign gj_full = bba_pkg::lowest_set(bba_pkg::MAX_WORD_BITS'(gfree));
  assign gj = gj_full[WLOG-1:0];
  assign found_word = gbase + 32'(gj);
  assign last_group = (gbase + 32'(WB)) >= nwords;

  assign wbase = 32'(word_q) << WLOG;
  assign wmask = bba_pkg::low_mask(bba_pkg::sat_sub(32'(size), wbase));
  assign wfree = ~map_rdata & wmask[WB-1:0];
  assign wp_full = bba_pkg::lowest_set(bba_pkg::MAX_WORD_BITS'(wfree));
  assign wp = wp_full[WLOG-1:0];
  assign wset = map_rdata | (one_bit << wp);

  assign word_group = 32'(word_q) >> WLOG;
  assign flag_bit = one_bit << word_q[WLOG-1:0];
  assign idx_bit = one_bit << bit_q;

  assign sbase = 32'(sweep) << WLOG;
  assign sword_mask = bba_pkg::low_mask(bba_pkg::sat_sub(32'(res_q), sbase));
  assign sflag_mask = bba_pkg::low_mask(bba_pkg::sat_sub(32'(res_q) >> WLOG, sbase));
  assign sweep_word = sword_mask[WB-1:0];
  assign sweep_flags = sflag_mask[WB-1:0];

  assign map_raddr = (state == S_SCAN) ? found_word[AW-1:0] : req_word[AW-1:0];

  always_comb begin
    if (state == S_IDLE) begin
      if (request.payload.cmd == bba_pkg::CMD_ALLOC) begin
        sum_raddr = '0;
      end else begin
        sum_raddr = req_group[GAW-1:0];
      end
    end else begin
      sum_raddr = grp + GAW'(1);
    end
  end

  always_comb begin
    map_we = 1'b0;
    map_waddr = word_q;
    map_wdata = wset;
    sum_we = 1'b0;
    sum_waddr = word_group[GAW-1:0];
    sum_wdata = sum_hold | flag_bit;
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        map_waddr = sweep;
        map_wdata = sweep_word;
        sum_we = 32'(sweep) < 32'(NUM_GROUPS);
        sum_waddr = sweep[GAW-1:0];
        sum_wdata = sweep_flags;
      end
      S_WORD: begin
        map_we = |wfree;
        sum_we = (|wfree) && (&wset);
      end
      S_ACCESS: begin
        if (cmd_q == bba_pkg::CMD_FREE) begin
          map_we = 1'b1;
          map_wdata = map_rdata & ~idx_bit;
          sum_we = 1'b1;
          sum_wdata = sum_rdata & ~flag_bit;
        end
      end
      default: begin
      end
    endcase
  end

  bba_ram #(.WIDTH(WB), .DEPTH(NUM_WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bba_ram #(.WIDTH(WB), .DEPTH(NUM_GROUPS)) u_summary (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign request.ready = (state == S_IDLE);
  assign response.valid = rsp_valid;
  assign response.payload = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      res_q <= '0;
      init_op <= 1'b0;
      free_count <= '0;
      total_blocks <= bba_pkg::TOTAL_BLOCKS_RESET;
      reserved_blocks <= bba_pkg::RESERVED_BLOCKS_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bba_pkg::REG_TOTAL_BLOCKS: total_blocks <= cfg_wdata;
          bba_pkg::REG_RESERVED_BLOCKS: reserved_blocks <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (state == S_DONE && (!rsp_valid || response.ready)) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (32'(sweep) == 32'(NUM_WORDS - 1)) begin
            sweep <= '0;
            pend_block <= '0;
            pend_bit <= 1'b0;
            pend_status <= bba_pkg::ST_OK;
            state <= init_op ? S_DONE : S_IDLE;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end
        S_IDLE: begin
          if (request.valid) begin
            cmd_q <= request.payload.cmd;
            word_q <= req_word[AW-1:0];
            bit_q <= request.payload.block_index[WLOG-1:0];
            grp <= '0;
            pend_bit <= 1'b0;
            case (request.payload.cmd)
              bba_pkg::CMD_INIT: begin
                pend_block <= request.payload.block_index;
                pend_status <= bba_pkg::ST_OK;
                res_q <= res_now;
                init_op <= 1'b1;
                free_count <= size - res_now;
                state <= S_CLEAR;
              end
              bba_pkg::CMD_ALLOC: begin
                pend_block <= '0;
                if (free_count == '0 || nwords == 32'd0) begin
                  pend_status <= bba_pkg::ST_NOFREE;
                  state <= S_DONE;
                end else begin
                  pend_status <= bba_pkg::ST_OK;
                  state <= S_SCAN;
                end
              end
              default: begin
                pend_block <= request.payload.block_index;
                if (!in_range) begin
                  pend_status <= bba_pkg::ST_RANGE;
                  state <= S_DONE;
                end else begin
                  pend_status <= bba_pkg::ST_OK;
                  state <= S_ACCESS;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (|gfree) begin
            word_q <= found_word[AW-1:0];
            sum_hold <= sum_rdata;
            state <= S_WORD;
          end else if (last_group) begin
            pend_status <= bba_pkg::ST_NOFREE;
            state <= S_DONE;
          end else begin
            grp <= grp + GAW'(1);
          end
        end
        S_WORD: begin
          if (|wfree) begin
            pend_block <= IW'(wbase + 32'(wp));
            pend_bit <= 1'b1;
            free_count <= free_count - CW'(1);
          end else begin
            pend_status <= bba_pkg::ST_NOFREE;
          end
          state <= S_DONE;
        end
        S_ACCESS: begin
          if (cmd_q == bba_pkg::CMD_FREE) begin
            if (free_count < size) begin
              free_count <= free_count + CW'(1);
            end
          end else begin
            pend_bit <= map_rdata[bit_q];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || response.ready) begin
            rsp.result_block <= pend_block;
            rsp.bit_value <= pend_bit;
            rsp.free_blocks <= free_count;
            rsp.status <= pend_status;
            init_op <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_request_after_reset: assert property (@(posedge clk) rst |=> !request.ready)
    else $error("request taken during reset clearing pass");

  a_alloc_decrements: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORD && map_we) |=> (free_count == CW'($past(free_count) - CW'(1))))
    else $error("allocate did not take exactly one block from the count");

  a_summary_with_map: assert property (@(posedge clk) disable iff (rst)
    (sum_we && state != S_CLEAR) |-> map_we)
    else $error("summary updated without a bitmap update");

  a_nofree_fields: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.payload.status == bba_pkg::ST_NOFREE) |->
    (response.payload.bit_value == 1'b0 && response.payload.result_block == '0))
    else $error("failed allocate returned a block");

endmodule

>>> tb/tb_block_bitmap_allocator.sv
module tb_block_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BLOCKS = bba_pkg::MAP_BLOCKS_DEF;
  localparam int CFG_W = bba_pkg::CFG_W;
  localparam int IDX_W = bba_pkg::IDX_W;

  logic clk;
  logic rst;
  logic cfg_we;
  bba_pkg::reg_index_t cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  bba_stream_if #(.payload_t(bba_pkg::request_t)) request_if ();
  bba_stream_if #(.payload_t(bba_pkg::response_t)) response_if ();

  block_bitmap_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .request   (request_if),
    .response  (response_if)
  );

  bit used_map [MAP_BLOCKS];
  logic [CFG_W-1:0] free_cnt = '0;
  logic [CFG_W-1:0] total_reg = bba_pkg::TOTAL_BLOCKS_RESET;
  logic [CFG_W-1:0] reserved_reg = bba_pkg::RESERVED_BLOCKS_RESET;

  bba_pkg::response_t pending_rsp [$];
  bba_pkg::response_t want_rsp;
  bba_pkg::response_t got_rsp;
  bit rsp_bad;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int managed_blocks();
    return (total_reg < MAP_BLOCKS) ? int'(total_reg) : MAP_BLOCKS;
  endfunction

  function automatic bba_pkg::response_t predict_response(bba_pkg::request_t req);
    bba_pkg::response_t rsp;
    int size;
    int res;
    int slot;
    int idx;
    size = managed_blocks();
    idx = int'(req.block_index);
    rsp = '{result_block: '0, bit_value: 1'b0, free_blocks: '0, status: bba_pkg::ST_OK};
    case (req.cmd)
      bba_pkg::CMD_INIT: begin
        res = (reserved_reg < size) ? int'(reserved_reg) : size;
        for (int i = 0; i < MAP_BLOCKS; i++) used_map[i] = (i < res);
        free_cnt = CFG_W'(size - res);
      end
      bba_pkg::CMD_ALLOC: begin
        slot = 0;
        if (free_cnt != 0) begin
          while (slot < size && used_map[slot]) slot++;
        end
        if (free_cnt != 0 && slot < size) begin
          used_map[slot] = 1'b1;
          free_cnt = free_cnt - 1'b1;
          rsp.result_block = IDX_W'(slot);
          rsp.bit_value = 1'b1;
        end else begin
          rsp.status = bba_pkg::ST_NOFREE;
        end
      end
      default: begin
        rsp.result_block = req.block_index;
        if (idx >= size) begin
          rsp.status = bba_pkg::ST_RANGE;
        end else if (req.cmd == bba_pkg::CMD_FREE) begin
          used_map[idx] = 1'b0;
          if (free_cnt < size) free_cnt = free_cnt + 1'b1;
        end else begin
          rsp.bit_value = used_map[idx];
        end
      end
    endcase
    rsp.free_blocks = free_cnt;
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst && response_if.valid && response_if.ready) begin
      got_rsp = response_if.payload;
      n_checked++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: expected no response, got block %0d bit %0d free %0d status %0d",
                 $time, got_rsp.result_block, got_rsp.bit_value, got_rsp.free_blocks,
                 got_rsp.status);
        n_fail++;
      end else begin
        want_rsp = pending_rsp.pop_front();
        rsp_bad = 1'b0;
        if (got_rsp.result_block !== want_rsp.result_block) begin
          $display("%0t: result_block expected %0d, got %0d", $time,
                   want_rsp.result_block, got_rsp.result_block);
          rsp_bad = 1'b1;
        end
        if (got_rsp.bit_value !== want_rsp.bit_value) begin
          $display("%0t: bit_value expected %0d, got %0d", $time,
                   want_rsp.bit_value, got_rsp.bit_value);
          rsp_bad = 1'b1;
        end
        if (got_rsp.free_blocks !== want_rsp.free_blocks) begin
          $display("%0t: free_blocks expected %0d, got %0d", $time,
                   want_rsp.free_blocks, got_rsp.free_blocks);
          rsp_bad = 1'b1;
        end
        if (got_rsp.status !== want_rsp.status) begin
          $display("%0t: status expected %0d, got %0d", $time,
                   want_rsp.status, got_rsp.status);
          rsp_bad = 1'b1;
        end
        if (rsp_bad) n_fail++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      response_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      response_if.ready <= 1'b0;
    end else begin
      response_if.ready <= 1'b1;
    end
  end

  task automatic send_request(bba_pkg::cmd_t cmd, logic [IDX_W-1:0] block_index);
    bba_pkg::request_t req;
    req.cmd = cmd;
    req.block_index = block_index;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      request_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    request_if.valid <= 1'b1;
    request_if.payload <= req;
    @(posedge clk);
    while (!request_if.ready) @(posedge clk);
    pending_rsp.push_back(predict_response(req));
    n_sent++;
  endtask

  task automatic wait_idle();
    request_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] total, logic [CFG_W-1:0] reserved);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= bba_pkg::REG_TOTAL_BLOCKS;
    cfg_wdata <= total;
    @(posedge clk);
    total_reg = total;
    cfg_index <= bba_pkg::REG_RESERVED_BLOCKS;
    cfg_wdata <= reserved;
    @(posedge clk);
    reserved_reg = reserved;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int size);
    case ($urandom_range(0, 9))
      0: return IDX_W'($urandom);
      1: return IDX_W'((size > 0) ? size - 1 : 0);
      2: return IDX_W'(size);
      default: return (size > 0) ? IDX_W'($urandom_range(0, size - 1)) : IDX_W'($urandom);
    endcase
  endfunction

  task automatic test_after_reset();
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    send_request(bba_pkg::CMD_QUERY, 16'hFFFF);
    send_request(bba_pkg::CMD_FREE, 16'h0007);
    send_request(bba_pkg::CMD_ALLOC, 16'hFFFF);
  endtask

  task automatic test_init_and_range();
    set_sizes(17'd16, 17'd4);
    send_request(bba_pkg::CMD_INIT, 16'hFFFF);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    send_request(bba_pkg::CMD_QUERY, 16'd3);
    send_request(bba_pkg::CMD_QUERY, 16'd16);
    send_request(bba_pkg::CMD_FREE, 16'hFFFF);
  endtask

  task automatic test_double_free_and_no_clear_bit();
    set_sizes(17'd4, 17'd0);
    send_request(bba_pkg::CMD_INIT, 16'h0000);
    send_request(bba_pkg::CMD_FREE, 16'd0);
    repeat (4) send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    send_request(bba_pkg::CMD_FREE, 16'd2);
    send_request(bba_pkg::CMD_FREE, 16'd2);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
  endtask

  task automatic test_reserved_beyond_size();
    set_sizes(17'd10, 17'd20);
    send_request(bba_pkg::CMD_INIT, 16'h0000);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
  endtask

  task automatic test_size_zero();
    set_sizes(17'd0, 17'd0);
    send_request(bba_pkg::CMD_INIT, 16'h0000);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    send_request(bba_pkg::CMD_QUERY, 16'd0);
  endtask

  task automatic test_size_change_without_init();
    set_sizes(17'd64, 17'd0);
    send_request(bba_pkg::CMD_INIT, 16'h0000);
    repeat (3) send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    set_sizes(17'd2, 17'd0);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
    send_request(bba_pkg::CMD_QUERY, 16'd2);
    send_request(bba_pkg::CMD_FREE, 16'd1);
  endtask

  task automatic test_register_extremes();
    set_sizes(17'h1FFFF, 17'h1FFFF);
    send_request(bba_pkg::CMD_INIT, 16'h0000);
    send_request(bba_pkg::CMD_FREE, 16'hFFFF);
    send_request(bba_pkg::CMD_ALLOC, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int total;
    int reserved;
    int alloc_share;
    int r;
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph < 8);
      if (ph == 3) begin
        total = MAP_BLOCKS;
        reserved = $urandom_range(0, MAP_BLOCKS);
      end else if (ph == 6) begin
        total = 17'h1FFFF;
        reserved = $urandom_range(MAP_BLOCKS - 140, MAP_BLOCKS);
      end else begin
        total = $urandom_range(1, 80);
        reserved = $urandom_range(0, total + 4);
      end
      alloc_share = (ph % 2 == 0) ? 70 : 40;
      set_sizes(CFG_W'(total), CFG_W'(reserved));
      send_request(bba_pkg::CMD_INIT, IDX_W'($urandom));
      repeat (64) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_request(bba_pkg::CMD_INIT, IDX_W'($urandom));
        else if (r < 3 + alloc_share) send_request(bba_pkg::CMD_ALLOC, IDX_W'($urandom));
        else if (r < 3 + alloc_share + (97 - alloc_share) / 2)
          send_request(bba_pkg::CMD_FREE, pick_index(managed_blocks()));
        else send_request(bba_pkg::CMD_QUERY, pick_index(managed_blocks()));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= bba_pkg::REG_TOTAL_BLOCKS;
    cfg_wdata <= '0;
    request_if.valid <= 1'b0;
    request_if.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_init_and_range();
    test_double_free_and_no_clear_bit();
    test_reserved_beyond_size();
    test_size_zero();
    test_size_change_without_init();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (32) @(posedge clk);
    $display("Covered init, allocate, free and query over %0d size settings.", n_settings);
    $display("Sent %0d commands, checked %0d responses, %0d bad.", n_sent, n_checked, n_fail);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
